// ===== sv/atmowc_pkg.sv =====
// shared constants, types and codes for the trimmed mean / open wire check block
package atmowc_pkg;

  localparam int CONVERSIONS = 16;
  localparam int SAMPLE_BITS = 10;
  localparam int CODE_BITS   = 10;
  localparam int THRESH_BITS = 10;
  localparam int KIND_BITS   = 2;

  localparam int CNT_BITS  = $clog2(CONVERSIONS);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(CONVERSIONS);

  localparam int DIVISOR    = CONVERSIONS - 2;
  localparam int DIV_LOG    = $clog2(DIVISOR);
  localparam int DIV_SHIFT  = SUM_BITS + DIV_LOG;
  localparam int RECIP_BITS = SUM_BITS + 1;
  localparam int PROD_BITS  = DIV_SHIFT + SUM_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((longint'(1) << DIV_SHIFT) / DIVISOR) + 1);

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = '1;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(600);

  localparam int IN_TDATA_BITS  = 16;
  localparam int IN_TUSER_BITS  = KIND_BITS;
  localparam int OUT_TDATA_BITS = 16;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_SPREAD_THRESHOLD = 1'b0;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PROBE_HIGH = 2'd0,
    KIND_PROBE_LOW  = 2'd1,
    KIND_ACCUM      = 2'd2
  } kind_t;

  typedef struct packed {
    logic                fault;
    logic [SUM_BITS-1:0] trim;
  } res_t;

endpackage

// ===== sv/atmowc_cfg.sv =====
// apb register file holding the probe spread threshold
module atmowc_cfg
  import atmowc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [THRESH_BITS-1:0]   threshold
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_BITS-1] == REG_SPREAD_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      threshold <= pwdata[THRESH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = APB_DATA_BITS'(threshold);
    end
  end

endmodule

// ===== sv/atmowc_acc.sv =====
// input register, probe compare and running sum / min / max accumulation
module atmowc_acc
  import atmowc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_TDATA_BITS-1:0] s_tdata,
  input  logic [IN_TUSER_BITS-1:0] s_tuser,
  input  logic [THRESH_BITS-1:0]   threshold,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res
);

  logic                   in_valid;
  kind_t                  in_kind;
  logic [SAMPLE_BITS-1:0] in_sample;

  logic [SAMPLE_BITS-1:0] probe_high;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SAMPLE_BITS-1:0] running_min;
  logic [SAMPLE_BITS-1:0] running_max;
  logic [CNT_BITS-1:0]    sample_count;

  logic [SAMPLE_BITS-1:0] probe_high_next;
  logic [SUM_BITS-1:0]    running_sum_next;
  logic [SAMPLE_BITS-1:0] running_min_next;
  logic [SAMPLE_BITS-1:0] running_max_next;
  logic [CNT_BITS-1:0]    sample_count_next;

  logic                   adv;
  logic                   take;
  logic                   emit;
  res_t                   res_next;

  logic [SUM_BITS-1:0]    sum_add;
  logic [SAMPLE_BITS-1:0] min_new;
  logic [SAMPLE_BITS-1:0] max_new;
  logic [SAMPLE_BITS-1:0] spread;
  logic                   last;

  assign adv      = !res_valid || res_ready;
  assign take     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= kind_t'(s_tuser);
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  assign sum_add = running_sum + SUM_BITS'(in_sample);
  assign min_new = (in_sample < running_min) ? in_sample : running_min;
  assign max_new = (in_sample > running_max) ? in_sample : running_max;
  assign last    = (sample_count == CNT_BITS'(CONVERSIONS - 1));
  assign spread  = (probe_high > in_sample) ? (probe_high - in_sample)
                                            : (in_sample - probe_high);

  always_comb begin
    probe_high_next   = probe_high;
    running_sum_next  = running_sum;
    running_min_next  = running_min;
    running_max_next  = running_max;
    sample_count_next = sample_count;
    emit              = 1'b0;
    res_next.fault    = 1'b0;
    res_next.trim     = sum_add - SUM_BITS'(min_new) - SUM_BITS'(max_new);
    if (take) begin
      case (in_kind)
        KIND_PROBE_HIGH: begin
          probe_high_next   = in_sample;
          running_sum_next  = '0;
          running_min_next  = FULL_SCALE;
          running_max_next  = '0;
          sample_count_next = '0;
        end
        KIND_PROBE_LOW: begin
          running_sum_next  = '0;
          running_min_next  = FULL_SCALE;
          running_max_next  = '0;
          sample_count_next = '0;
          if (spread >= threshold) begin
            emit           = 1'b1;
            res_next.fault = 1'b1;
          end
        end
        KIND_ACCUM: begin
          if (last) begin
            emit              = 1'b1;
            running_sum_next  = '0;
            running_min_next  = FULL_SCALE;
            running_max_next  = '0;
            sample_count_next = '0;
          end else begin
            running_sum_next  = sum_add;
            running_min_next  = min_new;
            running_max_next  = max_new;
            sample_count_next = sample_count + CNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_high   <= '0;
      running_sum  <= '0;
      running_min  <= FULL_SCALE;
      running_max  <= '0;
      sample_count <= '0;
    end else begin
      probe_high   <= probe_high_next;
      running_sum  <= running_sum_next;
      running_min  <= running_min_next;
      running_max  <= running_max_next;
      sample_count <= sample_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_probe_clears: assert property (@(posedge clk) disable iff (rst)
    take && (in_kind == KIND_PROBE_HIGH || in_kind == KIND_PROBE_LOW)
      |=> running_sum == '0 && sample_count == '0)
    else $error("probe word did not clear accumulators");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    sample_count == '0 |-> running_sum == '0 && running_max == '0
      && running_min == FULL_SCALE)
    else $error("accumulators not clear at zero count");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    sample_count != '0 |-> running_min <= running_max)
    else $error("running min above running max");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while stalled");
`endif

endmodule

// ===== sv/atmowc_div.sv =====
// reciprocal divide of the trimmed sum, clamp and output register
module atmowc_div
  import atmowc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      res_valid,
  output logic                      res_ready,
  input  res_t                      res,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  output logic                      m_tuser
);

  logic [PROD_BITS-1:0]   prod;
  logic [SUM_BITS-1:0]    quot;
  logic [CODE_BITS-1:0]   mean;
  logic [CODE_BITS-1:0]   code_next;
  logic [CODE_BITS-1:0]   code;
  logic                   fault;

  assign res_ready = !m_tvalid || m_tready;

  assign prod      = PROD_BITS'(res.trim) * PROD_BITS'(RECIP);
  assign quot      = prod[DIV_SHIFT +: SUM_BITS];
  assign mean      = (quot > SUM_BITS'(FULL_SCALE)) ? CODE_BITS'(FULL_SCALE)
                                                    : CODE_BITS'(quot);
  assign code_next = res.fault ? '0 : mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      code  <= code_next;
      fault <= res.fault;
    end
  end

  assign m_tdata = OUT_TDATA_BITS'(code);
  assign m_tuser = fault;

endmodule

// ===== sv/adc_trimmed_mean_open_wire_check_top.sv =====
// top level of the adc trimmed mean and open wire check block
//
//   channel  dir  handshake                       word
//   s_*      in   s_tvalid / s_tready             tdata: sample; tuser: kind
//   m_*      out  m_tvalid / m_tready             tdata: code; tuser: fault
//   apb      in   psel, penable, pwrite, pready   threshold at address 0
//
// one word accepted per cycle while the output is not stalled; a result leaves through
// the input register, the accumulate register and the divide and output register
// the mean uses a constant reciprocal multiply in the last stage
// rst is synchronous; it clears valids, accumulators and sets threshold to 600
// each register stage refills while the stage after it drains or is empty
module adc_trimmed_mean_open_wire_check_top
  import atmowc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // sample[9:0], zero pad
  input  logic [IN_TUSER_BITS-1:0]  s_tuser,   // kind[1:0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,   // code[9:0], zero pad
  output logic                      m_tuser,   // fault[0]
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_BITS-1:0]  paddr,
  input  logic [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0]  prdata,
  output logic                      pready
);

  logic [THRESH_BITS-1:0] threshold;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;

  atmowc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  atmowc_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .threshold (threshold),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  atmowc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
